[sv/assert_macros.svh]
// assertion macros shared by the parser rtl
// expects clk_i and rst_ni in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold on every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication checked on the following edge
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ipv4dp_pkg.sv]
// types and constants for the ipv4 dotted-decimal parser
// no dependencies
package ipv4dp_pkg;

  localparam int unsigned OctetW = 8;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned PhaseW = 2;

  // parse phase codes; code 3 behaves as trailing whitespace
  localparam logic [PhaseW-1:0] PH_LEAD  = 2'd0;
  localparam logic [PhaseW-1:0] PH_TEXT  = 2'd1;
  localparam logic [PhaseW-1:0] PH_TRAIL = 2'd2;

  localparam logic [OctetW-1:0] CHR_DOT   = 8'h2E;
  localparam logic [OctetW-1:0] CHR_ZERO  = 8'h30;
  localparam logic [OctetW-1:0] CHR_NINE  = 8'h39;
  localparam logic [OctetW-1:0] CHR_SPACE = 8'h20;
  localparam logic [OctetW-1:0] CHR_TAB   = 8'h09;
  localparam logic [OctetW-1:0] CHR_CR    = 8'h0D;

  localparam logic [AddrW-1:0] OCTET_MAX = 32'd255;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [AddrW-1:0]  acc;
    logic [AddrW-1:0]  addr;
    logic              dot;
    logic              err;
  } parse_state_t;

  typedef struct packed {
    logic [AddrW-1:0] address;
    logic             parse_error;
  } parse_result_t;

  localparam parse_state_t PARSE_RESET = '{
    phase: PH_LEAD,
    acc:   '0,
    addr:  '0,
    dot:   1'b0,
    err:   1'b0
  };

endpackage

[sv/ipv4dp_if.sv]
// valid/ready channel interfaces for the parser text input and address output
// depends on ipv4dp_pkg
interface ipv4dp_text_if;
  logic                       valid;
  logic                       ready;
  logic [ipv4dp_pkg::OctetW-1:0] text_byte;
  logic                       byte_present;
  logic                       end_of_text;

  modport source (output valid, output text_byte, output byte_present,
                  output end_of_text, input ready);
  modport sink (input valid, input text_byte, input byte_present,
                input end_of_text, output ready);
endinterface

interface ipv4dp_addr_if;
  logic                         valid;
  logic                         ready;
  logic [ipv4dp_pkg::AddrW-1:0] address;
  logic                         parse_error;

  modport source (output valid, output address, output parse_error, input ready);
  modport sink (input valid, input address, input parse_error, output ready);
endinterface

[sv/ipv4dp_step.sv]
// per-character update of the parser state and the end-of-string result
// depends on ipv4dp_pkg
module ipv4dp_step (
  input  ipv4dp_pkg::parse_state_t         state_i,
  input  logic [ipv4dp_pkg::OctetW-1:0]    text_byte_i,
  input  logic                             byte_present_i,
  input  logic                             end_of_text_i,
  output ipv4dp_pkg::parse_state_t         state_o,
  output ipv4dp_pkg::parse_result_t        result_o
);
  import ipv4dp_pkg::*;

  localparam int unsigned WideW = AddrW + 4;

  logic               is_blank;
  logic               is_digit;
  logic               is_dot;
  logic [WideW-1:0]   times_ten;
  logic [WideW-1:0]   digit_val;
  parse_state_t       nxt;

  assign is_blank = (text_byte_i == CHR_SPACE) ||
                    ((text_byte_i >= CHR_TAB) && (text_byte_i <= CHR_CR));
  assign is_digit = (text_byte_i >= CHR_ZERO) && (text_byte_i <= CHR_NINE);
  assign is_dot   = (text_byte_i == CHR_DOT);

  // acc * 10 as two shifted adds, 4 spare bits catch overflow past 32 bits
  assign times_ten = {1'b0, state_i.acc, 3'b000} + {3'b000, state_i.acc, 1'b0};
  assign digit_val = times_ten + {{(WideW-4){1'b0}}, text_byte_i[3:0]};

  always_comb begin
    nxt = state_i;
    if (byte_present_i && !state_i.err) begin
      if (is_blank) begin
        if (state_i.phase == PH_TEXT) begin
          nxt.phase = PH_TRAIL;
        end
      end else begin
        if (state_i.phase == PH_LEAD) begin
          nxt.phase = PH_TEXT;
        end
        if (nxt.phase == PH_TEXT) begin
          if (is_digit) begin
            if ((digit_val[WideW-1:AddrW] != 4'd0) ||
                (state_i.dot && (digit_val > {4'd0, OCTET_MAX}))) begin
              nxt.err = 1'b1;
            end else begin
              nxt.acc = digit_val[AddrW-1:0];
            end
          end else if (is_dot) begin
            if (state_i.acc > OCTET_MAX) begin
              nxt.err = 1'b1;
            end else begin
              nxt.dot  = 1'b1;
              nxt.addr = {state_i.addr[AddrW-OctetW-1:0], state_i.acc[OctetW-1:0]};
              nxt.acc  = '0;
            end
          end else begin
            nxt.err = 1'b1;
          end
        end else begin
          // non-blank after trailing whitespace
          nxt.err = 1'b1;
        end
      end
    end
  end

  always_comb begin
    result_o.parse_error = nxt.err || (nxt.phase == PH_LEAD);
    if (result_o.parse_error) begin
      result_o.address = '0;
    end else begin
      result_o.address = {nxt.addr[AddrW-OctetW-1:0], {OctetW{1'b0}}} | nxt.acc;
    end
  end

  assign state_o = end_of_text_i ? PARSE_RESET : nxt;

endmodule

[sv/ipv4_dotted_decimal_parser_unit.sv]
// channel      dir  payload                                   transfer when
// text_i       in   text_byte[7:0] byte_present end_of_text   valid && ready
// addr_o       out  address[31:0] parse_error                 valid && ready
//
// one character per cycle sustained, barring a stalled result; an item is
// held in the input register, then the parse state and result register
// update together. a result appears on addr_o once its end_of_text item
// leaves the input register; the next string can stream in while it waits.
// reset (rst_ni low, asynchronous) empties both registers and returns the
// parse state to leading whitespace. a stalled result only holds back an
// end_of_text item; plain characters keep flowing.
// depends on ipv4dp_pkg, ipv4dp_if, ipv4dp_step, assert_macros.svh
module ipv4_dotted_decimal_parser_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  ipv4dp_text_if.sink   text_i,
  ipv4dp_addr_if.source addr_o
);
  import ipv4dp_pkg::*;
  `include "assert_macros.svh"

  logic                s1_valid_q, s1_valid_d;
  logic [OctetW-1:0]   s1_byte_q;
  logic                s1_present_q;
  logic                s1_eot_q;
  logic                in_fire;
  logic                s1_fire;
  logic                out_free;

  parse_state_t        state_q, state_d;
  parse_state_t        step_state;
  parse_result_t       step_result;

  logic                out_valid_q, out_valid_d;
  parse_result_t       out_q;

  assign out_free = !out_valid_q || addr_o.ready;
  assign s1_fire  = s1_valid_q && (!s1_eot_q || out_free);
  assign text_i.ready = !s1_valid_q || s1_fire;
  assign in_fire  = text_i.valid && text_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q    <= text_i.text_byte;
      s1_present_q <= text_i.byte_present;
      s1_eot_q     <= text_i.end_of_text;
    end
  end

  ipv4dp_step u_step (
    .state_i        (state_q),
    .text_byte_i    (s1_byte_q),
    .byte_present_i (s1_present_q),
    .end_of_text_i  (s1_eot_q),
    .state_o        (step_state),
    .result_o       (step_result)
  );

  assign state_d = s1_fire ? step_state : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PARSE_RESET;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire && s1_eot_q) begin
      out_valid_d = 1'b1;
    end else if (addr_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_eot_q) begin
      out_q <= step_result;
    end
  end

  assign addr_o.valid       = out_valid_q;
  assign addr_o.address     = out_q.address;
  assign addr_o.parse_error = out_q.parse_error;

  // rejected strings carry a zero address
  `ASSERT_IMPLIES(a_err_zero_addr, out_valid_q && out_q.parse_error,
                  out_q.address == '0, "error result with non-zero address")
  // the end of a string always leaves a clean parse state
  `ASSERT_NEXT(a_eot_clears, s1_fire && s1_eot_q,
               state_q == PARSE_RESET, "parse state not cleared after string end")
  // a result only appears after an end_of_text item leaves the input register
  `ASSERT_IMPLIES(a_out_from_eot, $rose(out_valid_q),
                  $past(s1_fire && s1_eot_q), "result without end of string")
  // after a dot the running octet never exceeds 255
  `ASSERT_ALWAYS(a_octet_bound, !state_q.dot || (state_q.acc <= OCTET_MAX),
                 "octet above 255 after a dot")

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// self-checking testbench for ipv4_dotted_decimal_parser_unit
// drives text strings byte by byte and checks each parsed address against a shadow parser
// depends on ipv4dp_pkg, ipv4dp_if and the parser rtl
module testbench;
  import ipv4dp_pkg::*;

  localparam int unsigned PresentTarget = 950;
  localparam int unsigned CycleLimit    = 300000;
  localparam int unsigned DrainLimit    = 2000;
  localparam int unsigned TailCycles    = 10;

  typedef struct {
    logic [OctetW-1:0] text_byte;
    logic              byte_present;
    logic              end_of_text;
    bit                hold_for_drain;
  } text_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ipv4dp_text_if text_if ();
  ipv4dp_addr_if addr_if ();

  ipv4_dotted_decimal_parser_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .text_i (text_if),
    .addr_o (addr_if)
  );

  always #4 clk_i = ~clk_i;

  text_item_t    pending_text[$];
  parse_result_t predicted_results[$];
  logic [7:0]    spell_q[$];
  parse_state_t  shadow = PARSE_RESET;

  bit hold_next;
  int present_total;
  int item_total;
  int eot_total;
  int errors;
  int cycle_count;

  // driver-side bookkeeping
  int items_sent;
  int strings_in;
  int results_in;
  int tx_gap;

  // monitor-side bookkeeping
  int results_seen;
  int rx_gap;

  function automatic bit is_blank(logic [7:0] c);
    return c == CHR_SPACE || (c >= CHR_TAB && c <= CHR_CR);
  endfunction

  // one accepted item through the shadow parser
  task automatic advance_parser(input logic [7:0] c, input logic present, input logic eot,
                                output bit done, output parse_result_t res);
    logic [AddrW+3:0] grown;
    done = 1'b0;
    res  = '0;
    if (present && !shadow.err) begin
      if (is_blank(c)) begin
        if (shadow.phase == PH_TEXT) shadow.phase = PH_TRAIL;
      end else begin
        if (shadow.phase == PH_LEAD) shadow.phase = PH_TEXT;
        if (shadow.phase != PH_TEXT) begin
          shadow.err = 1'b1;
        end else if (c >= CHR_ZERO && c <= CHR_NINE) begin
          grown = {4'd0, shadow.acc} * 36'd10 + {28'd0, c - CHR_ZERO};
          if (grown > 36'hFFFFFFFF || (shadow.dot && grown > {4'd0, OCTET_MAX})) begin
            shadow.err = 1'b1;
          end else begin
            shadow.acc = grown[AddrW-1:0];
          end
        end else if (c == CHR_DOT) begin
          if (shadow.acc > OCTET_MAX) begin
            shadow.err = 1'b1;
          end else begin
            shadow.dot  = 1'b1;
            shadow.addr = (shadow.addr << 8) | shadow.acc;
            shadow.acc  = '0;
          end
        end else begin
          shadow.err = 1'b1;
        end
      end
    end
    if (eot) begin
      done = 1'b1;
      if (shadow.err || shadow.phase == PH_LEAD) begin
        res.address     = '0;
        res.parse_error = 1'b1;
      end else begin
        res.address     = (shadow.addr << 8) | shadow.acc;
        res.parse_error = 1'b0;
      end
      shadow = PARSE_RESET;
    end
  endtask

  task automatic add_item(input logic [7:0] c, input logic present, input logic eot);
    text_item_t it;
    it.text_byte      = c;
    it.byte_present   = present;
    it.end_of_text    = eot;
    it.hold_for_drain = hold_next;
    hold_next = 1'b0;
    pending_text.push_back(it);
    if (present) present_total++;
    if (eot) eot_total++;
  endtask

  function automatic logic [7:0] random_blank();
    if ($urandom_range(0, 2) == 0) return CHR_SPACE;
    return CHR_TAB + 8'($urandom_range(0, 4));
  endfunction

  function automatic int random_octet();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic spell_number(input longint unsigned v);
    string s;
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 3)) spell_q.push_back(CHR_ZERO);
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) spell_q.push_back(s[i]);
  endtask

  // absent bytes are sprinkled in; the string ends on its last byte or on an absent item
  task automatic emit_spelling();
    bit absent_end;
    absent_end = (spell_q.size() == 0) || ($urandom_range(0, 2) == 0);
    foreach (spell_q[i]) begin
      if ($urandom_range(0, 15) == 0) add_item(8'($urandom), 1'b0, 1'b0);
      add_item(spell_q[i], 1'b1, !absent_end && (i == spell_q.size() - 1));
    end
    if (absent_end) add_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic add_random_string();
    int kind;
    int n;
    int pos;
    longint unsigned v;
    logic [7:0] junk;
    spell_q.delete();
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0)
      spell_q.push_back(random_blank());
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 4;
      for (int i = 0; i < n; i++) begin
        if (i != 0) spell_q.push_back(CHR_DOT);
        spell_number(random_octet());
      end
    end else if (kind < 62) begin
      // plain number with no dot, some around the 32-bit limit
      case ($urandom_range(0, 4))
        0: v = 64'hFFFFFFFF;
        1: v = 64'h100000000 + $urandom_range(0, 9);
        2: v = {30'd0, 2'($urandom_range(0, 3)), 32'($urandom)};
        3: v = $urandom_range(0, 999);
        default: v = $urandom;
      endcase
      spell_number(v);
    end else if (kind < 74) begin
      n = $urandom_range(2, 4);
      for (int i = 0; i < n; i++) begin
        if (i != 0) spell_q.push_back(CHR_DOT);
        case ($urandom_range(0, 3))
          0: spell_number($urandom_range(256, 999));
          1: ;
          default: spell_number(random_octet());
        endcase
      end
    end else if (kind < 86) begin
      for (int i = 0; i < 4; i++) begin
        if (i != 0) spell_q.push_back(CHR_DOT);
        spell_number(random_octet());
      end
      pos  = $urandom_range(0, spell_q.size());
      junk = ($urandom_range(0, 1) == 0) ? random_blank() : 8'($urandom_range(0, 255));
      spell_q.insert(pos, junk);
    end else begin
      repeat ($urandom_range(1, 10)) begin
        case ($urandom_range(0, 3))
          0: spell_q.push_back(8'($urandom_range(0, 255)));
          1: spell_q.push_back(CHR_DOT);
          2: spell_q.push_back(random_blank());
          default: spell_q.push_back(CHR_ZERO + 8'($urandom_range(0, 9)));
        endcase
      end
    end
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0)
      spell_q.push_back(random_blank());
    emit_spelling();
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : text_driver
    bit            done;
    parse_result_t res;
    bit            calm;
    if (!rst_ni) begin
      text_if.valid        <= 1'b0;
      text_if.text_byte    <= '0;
      text_if.byte_present <= 1'b0;
      text_if.end_of_text  <= 1'b0;
      tx_gap = 0;
    end else begin
      calm = (items_sent >= item_total - 120) || ((items_sent / 50) % 3 == 2);
      if (addr_if.valid && addr_if.ready) results_in++;
      if (text_if.valid && text_if.ready) begin
        advance_parser(text_if.text_byte, text_if.byte_present, text_if.end_of_text, done, res);
        if (done) begin
          predicted_results.push_back(res);
          strings_in++;
        end
        items_sent++;
        if (!calm && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(1, 8);
      end
      if (!(text_if.valid && !text_if.ready)) begin
        if (tx_gap > 0) begin
          tx_gap--;
          text_if.valid <= 1'b0;
        end else if (pending_text.size() != 0 &&
                     !(pending_text[0].hold_for_drain && strings_in != results_in)) begin
          text_if.valid        <= 1'b1;
          text_if.text_byte    <= pending_text[0].text_byte;
          text_if.byte_present <= pending_text[0].byte_present;
          text_if.end_of_text  <= pending_text[0].end_of_text;
          void'(pending_text.pop_front());
        end else begin
          text_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : addr_monitor
    parse_result_t want;
    bit            calm;
    if (!rst_ni) begin
      addr_if.ready <= 1'b0;
      rx_gap = 0;
    end else begin
      calm = (results_seen >= eot_total - 10) || ((results_seen / 4) % 3 == 2);
      if (addr_if.valid && addr_if.ready) begin
        results_seen++;
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got address %h parse_error %b",
                   $time, addr_if.address, addr_if.parse_error);
          errors++;
        end else begin
          want = predicted_results.pop_front();
          if (addr_if.address !== want.address) begin
            $display("%0t: address mismatch, expected %h, got %h",
                     $time, want.address, addr_if.address);
            errors++;
          end
          if (addr_if.parse_error !== want.parse_error) begin
            $display("%0t: parse_error mismatch, expected %b, got %b",
                     $time, want.parse_error, addr_if.parse_error);
            errors++;
          end
        end
      end
      if (rx_gap > 0) begin
        rx_gap--;
        addr_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        rx_gap = $urandom_range(1, 8) - 1;
        addr_if.ready <= 1'b0;
      end else begin
        addr_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int settle;
    rst_ni = 1'b0;

    // empty string, absent byte only
    add_item(8'h00, 1'b0, 1'b1);
    // whitespace only
    add_item(CHR_TAB, 1'b1, 1'b0);
    add_item(CHR_CR, 1'b1, 1'b1);
    // trailing newline, end on an absent item
    add_item("0", 1'b1, 1'b0);
    add_item(CHR_DOT, 1'b1, 1'b0);
    add_item("2", 1'b1, 1'b0);
    add_item("5", 1'b1, 1'b0);
    add_item("5", 1'b1, 1'b0);
    add_item(8'h0A, 1'b1, 1'b0);
    add_item(8'hFF, 1'b0, 1'b1);
    // whitespace between digits
    add_item("1", 1'b1, 1'b0);
    add_item(CHR_SPACE, 1'b1, 1'b0);
    add_item("2", 1'b1, 1'b1);
    // bytes that are neither digit, dot nor blank
    add_item(8'hFF, 1'b1, 1'b1);
    add_item(8'h00, 1'b1, 1'b1);
    // octet over 255 closed by a dot
    add_item("2", 1'b1, 1'b0);
    add_item("5", 1'b1, 1'b0);
    add_item("6", 1'b1, 1'b0);
    add_item(CHR_DOT, 1'b1, 1'b1);
    // extra dots push the first octet out of the top
    add_item("7", 1'b1, 1'b0);
    repeat (4) add_item(CHR_DOT, 1'b1, 1'b0);
    add_item("8", 1'b1, 1'b1);
    // absent bytes in the middle change nothing
    add_item("9", 1'b1, 1'b0);
    add_item(8'h5A, 1'b0, 1'b0);
    add_item(8'h00, 1'b0, 1'b1);

    hold_next = 1'b1;
    while (present_total < PresentTarget) begin
      if ($urandom_range(0, 19) == 0) hold_next = 1'b1;
      add_random_string();
    end
    item_total = pending_text.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_text.size() != 0 || text_if.valid) @(negedge clk_i);
    settle = 0;
    while (predicted_results.size() != 0 && settle < DrainLimit) begin
      @(negedge clk_i);
      settle++;
    end
    repeat (TailCycles) @(negedge clk_i);
    if (predicted_results.size() != 0) begin
      $display("%0t: %0d results never arrived, expected address %h parse_error %b",
               $time, predicted_results.size(), predicted_results[0].address,
               predicted_results[0].parse_error);
      errors++;
    end
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
